/* hdl/dgt_pkg.sv */
// Shared constants, types and payload structures of the depth grid triangulator.
package dgt_pkg;

	// Largest image the row store and the counters are sized for.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// Field widths of the register file and of the stream payloads.
	localparam int SIZE_W  = 11;
	localparam int CUT_W   = 34;
	localparam int COORD_W = 16;
	localparam int IDX_W   = 20;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// Triangle queue between the front and the back. Depth is a power of two.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Register indexes; each register occupies an eight-byte slot.
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_CUTOFF = 2'd2
	} reg_idx_t;

	// One xyz point; x sits in the lowest bits, as on the input stream.
	typedef struct packed {
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} point_t;

	// One triangle as three pixel indices plus the last-of-quad mark.
	typedef struct packed {
		logic             run_end;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] a;
	} tri_t;

	// Up to two triangles written into the queue in one cycle, first one first.
	typedef struct packed {
		logic [1:0] count;
		tri_t       first;
		tri_t       second;
	} push_t;

	// Effective configuration, sizes already clamped to their legal range.
	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic [CUT_W-1:0]  cut;
	} cfg_t;

endpackage

/* hdl/dgt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module dgt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read returns the old contents when both ports hit the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/dgt_front.sv */
// Front end: pixel counters, row store, edge length tests and quad classification.
module dgt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  dgt_pkg::cfg_t       cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  dgt_pkg::point_t     s_tdata,
	input  logic                q_room,
	output dgt_pkg::push_t      push
);

	typedef logic [2:0][31:0] sq3_t;

	logic [dgt_pkg::COL_W-1:0] col_q;
	logic [dgt_pkg::ROW_W-1:0] row_q;
	logic [dgt_pkg::IDX_W-1:0] pix_q;
	dgt_pkg::point_t           left_q;
	dgt_pkg::point_t           ul_q;
	dgt_pkg::point_t           above;

	logic accept, col_end, row_end;
	logic rdy1, rdy2, rdy3, adv1, adv2, adv3;

	// Stage 1: row store read in flight.
	logic                      valid_s1, quad_s1;
	dgt_pkg::point_t           p2_s1, p3_s1;
	logic [dgt_pkg::IDX_W-1:0] i3_s1;

	// Stage 2: the four corners of the quad.
	logic                      valid_s2, quad_s2;
	dgt_pkg::point_t           p0_s2, p1_s2, p2_s2, p3_s2;
	logic [dgt_pkg::IDX_W-1:0] i0_s2, i1_s2, i2_s2, i3_s2;

	// Stage 3: squared coordinate differences per edge.
	logic                      valid_s3, quad_s3;
	sq3_t                      sq01_s3, sq02_s3, sq03_s3, sq31_s3, sq32_s3;
	logic [dgt_pkg::IDX_W-1:0] i0_s3, i1_s3, i2_s3, i3_s3;

	logic          e01, e02, e03, e31, e32;
	logic          t0, t1, t2, t3, ka, kb;
	dgt_pkg::tri_t ta, tb;

	function automatic sq3_t pair_sq(input dgt_pkg::point_t a, input dgt_pkg::point_t b);
		logic signed [16:0] dx, dy, dz;
		logic signed [33:0] px, py, pz;
		sq3_t               r;
		dx = signed'({a.x[15], a.x}) - signed'({b.x[15], b.x});
		dy = signed'({a.y[15], a.y}) - signed'({b.y[15], b.y});
		dz = signed'({a.z[15], a.z}) - signed'({b.z[15], b.z});
		px = dx * dx;
		py = dy * dy;
		pz = dz * dz;
		r[0] = px[31:0];
		r[1] = py[31:0];
		r[2] = pz[31:0];
		return r;
	endfunction

	function automatic logic [dgt_pkg::CUT_W-1:0] sum3(input sq3_t s);
		return {2'b00, s[0]} + {2'b00, s[1]} + {2'b00, s[2]};
	endfunction

	function automatic dgt_pkg::tri_t mk_tri(input logic [dgt_pkg::IDX_W-1:0] a,
	                                         input logic [dgt_pkg::IDX_W-1:0] b,
	                                         input logic [dgt_pkg::IDX_W-1:0] c);
		dgt_pkg::tri_t t;
		t.a       = a;
		t.b       = b;
		t.c       = c;
		t.run_end = 1'b0;
		return t;
	endfunction

	// Elastic pipeline: a stage takes new data when it is empty or moves on.
	assign rdy3 = !valid_s3 || q_room;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign adv3 = valid_s3 && q_room;
	assign adv2 = valid_s2 && rdy3;
	assign adv1 = valid_s1 && rdy2;

	assign s_tready = rdy1;
	assign accept   = s_tvalid && s_tready;

	assign col_end = dgt_pkg::SIZE_W'(col_q) >= cfg.width - dgt_pkg::SIZE_W'(1);
	assign row_end = dgt_pkg::SIZE_W'(row_q) >= cfg.height - dgt_pkg::SIZE_W'(1);

	// The read data is held by the RAM until the stage 1 item moves on.
	dgt_ram #(
		.WIDTH($bits(dgt_pkg::point_t)),
		.DEPTH(dgt_pkg::MAX_WIDTH)
	) u_row_store (
		.clk  (clk),
		.we   (accept),
		.waddr(col_q),
		.wdata(s_tdata),
		.re   (accept),
		.raddr(col_q),
		.rdata(above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			pix_q    <= '0;
			left_q   <= '0;
			ul_q     <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (accept) begin
				left_q <= s_tdata;
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q <= '0;
						pix_q <= '0;
					end else begin
						row_q <= row_q + dgt_pkg::ROW_W'(1);
						pix_q <= pix_q + dgt_pkg::IDX_W'(1);
					end
				end else begin
					col_q <= col_q + dgt_pkg::COL_W'(1);
					pix_q <= pix_q + dgt_pkg::IDX_W'(1);
				end
			end
			if (adv1) begin
				ul_q <= above;
			end
			if (rdy1) begin
				valid_s1 <= accept;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p3_s1   <= s_tdata;
			p2_s1   <= left_q;
			i3_s1   <= pix_q;
			quad_s1 <= (row_q != '0) && (col_q != '0);
		end
		if (adv1) begin
			p0_s2   <= ul_q;
			p1_s2   <= above;
			p2_s2   <= p2_s1;
			p3_s2   <= p3_s1;
			quad_s2 <= quad_s1;
			i3_s2   <= i3_s1;
			i2_s2   <= i3_s1 - dgt_pkg::IDX_W'(1);
			i1_s2   <= i3_s1 - dgt_pkg::IDX_W'(cfg.width);
			i0_s2   <= i3_s1 - dgt_pkg::IDX_W'(cfg.width) - dgt_pkg::IDX_W'(1);
		end
		if (adv2) begin
			sq01_s3 <= pair_sq(p0_s2, p1_s2);
			sq02_s3 <= pair_sq(p0_s2, p2_s2);
			sq03_s3 <= pair_sq(p0_s2, p3_s2);
			sq31_s3 <= pair_sq(p3_s2, p1_s2);
			sq32_s3 <= pair_sq(p3_s2, p2_s2);
			quad_s3 <= quad_s2;
			i0_s3   <= i0_s2;
			i1_s3   <= i1_s2;
			i2_s3   <= i2_s2;
			i3_s3   <= i3_s2;
		end
	end

	assign e01 = sum3(sq01_s3) <= cfg.cut;
	assign e02 = sum3(sq02_s3) <= cfg.cut;
	assign e03 = sum3(sq03_s3) <= cfg.cut;
	assign e31 = sum3(sq31_s3) <= cfg.cut;
	assign e32 = sum3(sq32_s3) <= cfg.cut;

	assign t0 = e02 && e01;
	assign t1 = e31 && e32;
	assign t2 = e03 && e01;
	assign t3 = e02 && e03;

	// The second diagonal is tried only when the first one keeps no face.
	always_comb begin
		if (t0 || t1) begin
			ka = t0;
			kb = t1;
			ta = mk_tri(i0_s3, i2_s3, i1_s3);
			tb = mk_tri(i3_s3, i1_s3, i2_s3);
		end else begin
			ka = t2;
			kb = t3;
			ta = mk_tri(i0_s3, i3_s3, i1_s3);
			tb = mk_tri(i0_s3, i2_s3, i3_s3);
		end
		if (!quad_s3) begin
			ka = 1'b0;
			kb = 1'b0;
		end

		push.count          = 2'd0;
		push.first          = ta;
		push.second         = tb;
		push.second.run_end = 1'b1;
		if (adv3) begin
			case ({ka, kb})
				2'b11: begin
					push.count = 2'd2;
				end
				2'b10: begin
					push.count         = 2'd1;
					push.first.run_end = 1'b1;
				end
				2'b01: begin
					push.count         = 2'd1;
					push.first         = tb;
					push.first.run_end = 1'b1;
				end
				default: begin
					push.count = 2'd0;
				end
			endcase
		end
	end

endmodule

/* hdl/dgt_queue.sv */
// Triangle queue between front and back: two writes and one read per cycle.
module dgt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  dgt_pkg::push_t push,
	output logic           room,
	input  logic           pop,
	output dgt_pkg::tri_t  head,
	output logic           head_valid
);

	dgt_pkg::tri_t               entries_q [dgt_pkg::Q_DEPTH];
	logic [dgt_pkg::Q_PTR_W-1:0] wr_q, rd_q;
	logic [dgt_pkg::Q_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + dgt_pkg::Q_PTR_W'(push.count);
			cnt_q <= cnt_q + dgt_pkg::Q_CNT_W'(push.count) - dgt_pkg::Q_CNT_W'(pop);
			if (pop) begin
				rd_q <= rd_q + dgt_pkg::Q_PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entries_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entries_q[wr_q + dgt_pkg::Q_PTR_W'(1)] <= push.second;
		end
	end

	// Room for a whole quad's worth of triangles, regardless of this cycle's pop.
	assign room       = cnt_q <= dgt_pkg::Q_CNT_W'(dgt_pkg::Q_DEPTH - 2);
	assign head       = entries_q[rd_q];
	assign head_valid = cnt_q != '0;

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> cnt_q <= dgt_pkg::Q_CNT_W'(dgt_pkg::Q_DEPTH - 2))
		else $error("triangle queue written without room for two entries");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("triangle queue read while empty");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd0 && !pop) |=> $stable(cnt_q) && $stable(rd_q))
		else $error("triangle queue level moved without a push or pop");

	a_pair_marks: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> !push.first.run_end && push.second.run_end)
		else $error("two-triangle quad carries a wrong last mark");

endmodule

/* hdl/dgt_back.sv */
// Back end: output register that drains the triangle queue onto the master stream.
module dgt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  dgt_pkg::tri_t head,
	input  logic          head_valid,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata,
	output logic          m_tlast
);

	dgt_pkg::tri_t out_q;
	logic          out_valid_q;

	assign pop = head_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.c, out_q.b, out_q.a};
	assign m_tlast  = out_q.run_end;

endmodule

/* hdl/depth_grid_triangulator.sv */
// Top level of the depth grid triangulator: register file and front, queue and back.
// Each triangle passes the front's stages, the queue and the back end's output register
// before it shows on m_tvalid; the second triangle of a quad follows the first.
// Throughput: one pixel per cycle while m_tready is high and each quad yields at most one
// triangle; pairs fill the queue, as the back end's output register takes one per cycle.
// Reset clears counters, pipeline valids, the queue and the registers (640, 480, 2500);
// the row store is not cleared and needs no clearing pass.
module depth_grid_triangulator (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// Pixel stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // point_x [15:0], point_y [31:16], point_z [47:32]
	// Triangle stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // corner_a [19:0], corner_b [39:20], corner_c [59:40], zero
	output logic        m_tlast   // run_end
);

	localparam logic [dgt_pkg::SIZE_W-1:0] WIDTH_RST  = dgt_pkg::SIZE_W'(640);
	localparam logic [dgt_pkg::SIZE_W-1:0] HEIGHT_RST = dgt_pkg::SIZE_W'(480);
	localparam logic [dgt_pkg::CUT_W-1:0]  CUTOFF_RST = dgt_pkg::CUT_W'(2500);

	logic [dgt_pkg::SIZE_W-1:0] width_q, height_q;
	logic [dgt_pkg::CUT_W-1:0]  cutoff_q;
	dgt_pkg::reg_idx_t          reg_idx;
	logic                       wr_en;

	dgt_pkg::cfg_t   cfg;
	dgt_pkg::push_t  push;
	dgt_pkg::tri_t   head;
	logic            q_room, head_valid, pop;

	function automatic logic [dgt_pkg::SIZE_W-1:0] clamp_size(
		input logic [dgt_pkg::SIZE_W-1:0] v,
		input logic [dgt_pkg::SIZE_W-1:0] hi
	);
		logic [dgt_pkg::SIZE_W-1:0] r;
		r = v;
		if (v < dgt_pkg::SIZE_W'(2)) begin
			r = dgt_pkg::SIZE_W'(2);
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// The port never waits; a write lands at the end of its access cycle.
	assign pready  = 1'b1;
	assign reg_idx = dgt_pkg::reg_idx_t'(paddr[4:3]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			cutoff_q <= CUTOFF_RST;
		end else if (wr_en) begin
			case (reg_idx)
				dgt_pkg::REG_WIDTH: begin
					width_q <= pwdata[dgt_pkg::SIZE_W-1:0];
				end
				dgt_pkg::REG_HEIGHT: begin
					height_q <= pwdata[dgt_pkg::SIZE_W-1:0];
				end
				dgt_pkg::REG_CUTOFF: begin
					cutoff_q <= pwdata[dgt_pkg::CUT_W-1:0];
				end
				default: begin
					// Writes past the last register are dropped.
				end
			endcase
		end
	end

	// Reads return the stored value, not the clamped one.
	always_comb begin
		case (reg_idx)
			dgt_pkg::REG_WIDTH:  prdata = 64'(width_q);
			dgt_pkg::REG_HEIGHT: prdata = 64'(height_q);
			dgt_pkg::REG_CUTOFF: prdata = 64'(cutoff_q);
			default:             prdata = '0;
		endcase
	end

	// Out-of-range sizes behave as the nearest legal size.
	assign cfg.width  = clamp_size(width_q, dgt_pkg::SIZE_W'(dgt_pkg::MAX_WIDTH));
	assign cfg.height = clamp_size(height_q, dgt_pkg::SIZE_W'(dgt_pkg::MAX_HEIGHT));
	assign cfg.cut    = cutoff_q;

	// The front accepts every pixel, keeps the previous row in its row store, runs
	// the edge tests in a three-stage pipeline and hands zero to two triangles per
	// pixel to the queue. It stalls only when the queue lacks room for two.
	dgt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_room  (q_room),
		.push    (push)
	);

	// The queue absorbs a quad's pair of triangles in one cycle and lets the front
	// run on while the output side is stalled.
	dgt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (q_room),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid)
	);

	// The back end moves one triangle per transaction to the output register.
	dgt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
